// ===== rtl/tod_pkg.sv =====
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types and codes for the tilt orientation debouncer: transaction
// payloads, orientation codes and register indexes.
// ----------------------------------------------------------------------------
package tod_pkg;

   // field widths
   localparam int unsigned AccelWidth  = 16;
   localparam int unsigned MagWidth    = 15;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned CsrDatWidth = 15;

   // orientation codes
   localparam logic [1:0] ORIENT_UPRIGHT  = 2'd0;
   localparam logic [1:0] ORIENT_INVERTED = 2'd1;
   localparam logic [1:0] ORIENT_RIGHT    = 2'd2;
   localparam logic [1:0] ORIENT_LEFT     = 2'd3;

   // candidate code for "no candidate yet"
   localparam logic [2:0] CAND_NONE = 3'd4;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_TILT_THRESHOLD = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_LIMIT = 1'b1;

   // register reset values
   localparam logic [MagWidth-1:0]   THRESHOLD_RESET = 15'd2500;
   localparam logic [CountWidth-1:0] LIMIT_RESET     = 8'd3;
   localparam logic [CountWidth-1:0] COUNT_MAX       = 8'd255;

   // input transaction
   typedef struct packed {
      logic signed [AccelWidth-1:0] accel_x;
      logic signed [AccelWidth-1:0] accel_y;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [1:0] orientation;
      logic       switched;
   } rsp_type;

   // saturating magnitude of a signed sample
   function automatic logic [MagWidth-1:0] magnitude(input logic [AccelWidth-1:0] v);
      logic [AccelWidth-1:0] neg;
      begin
         neg = ~v + 1'b1;
         if (!v[AccelWidth-1]) begin
            magnitude = v[MagWidth-1:0];
         end else if (neg[AccelWidth-1]) begin
            magnitude = {MagWidth{1'b1}};
         end else begin
            magnitude = neg[MagWidth-1:0];
         end
      end
   endfunction

endpackage

// ===== rtl/tilt_orientation_debouncer.sv =====
// ----------------------------------------------------------------------------
// tilt_orientation_debouncer
// Classifies accelerometer samples into an orientation and commits a new
// orientation only after it has been seen for a number of further samples.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | direction | moves
//   ---------+--------------------------------+-----------+-------------------
//   request  | req_valid, req_stall, req_data | in        | one X/Y sample
//   response | rsp_valid, rsp_stall, rsp_data | out       | orientation, flag
//   csr      | csr_we, csr_index, csr_wdata   | in        | register write
//
// One sample is accepted per cycle while the request side is not stalled; its
// result passes through the input register, then classify and state update
// into the result register, which drives the response port.
// The orientation state is fed back from its own registers, which sets the one-per-cycle rate.
// Reset is synchronous and returns orientation to upright with no candidate.
// A stalled response holds the result register and, once it holds a sample, the
// input register; the request side is stalled only while both are full.
//
module tilt_orientation_debouncer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tod_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tod_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [tod_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [tod_pkg::CsrDatWidth-1:0]      csr_wdata
);
   import tod_pkg::*;

   // configuration registers
   logic [MagWidth-1:0]   threshold_ff;
   logic [CountWidth-1:0] limit_ff;

   // pipeline registers
   logic    in_valid_ff;
   req_type in_ff;
   logic    out_valid_ff;
   rsp_type out_ff;

   // orientation state
   logic [1:0]            cur_ff, cur_in;
   logic [2:0]            cand_ff, cand_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  switched_in;

   // datapath
   logic                  out_free;
   logic                  in_move;
   logic [MagWidth-1:0]   mag_x, mag_y;
   logic                  x_pos, y_pos;
   logic [1:0]            raw;
   logic [CountWidth-1:0] count_inc;

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TILT_THRESHOLD: threshold_ff <= csr_wdata[MagWidth-1:0];
            CSR_DEBOUNCE_LIMIT: limit_ff     <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // raw orientation from the dominant axis
   always_comb begin
      mag_x = magnitude(in_ff.accel_x);
      mag_y = magnitude(in_ff.accel_y);
      x_pos = (in_ff.accel_x != '0) && !in_ff.accel_x[AccelWidth-1];
      y_pos = (in_ff.accel_y != '0) && !in_ff.accel_y[AccelWidth-1];
      raw   = cur_ff;
      if (mag_y > mag_x) begin
         if (mag_y > threshold_ff) begin
            raw = y_pos ? ORIENT_UPRIGHT : ORIENT_INVERTED;
         end
      end else if (mag_x > threshold_ff) begin
         raw = x_pos ? ORIENT_RIGHT : ORIENT_LEFT;
      end
   end

   // candidate tracking and commit
   always_comb begin
      cur_in      = cur_ff;
      cand_in     = cand_ff;
      count_in    = count_ff;
      switched_in = 1'b0;
      count_inc   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      if (raw != cur_ff) begin
         if ({1'b0, raw} == cand_ff) begin
            count_in = count_inc;
            if (count_inc >= limit_ff) begin
               cur_in      = raw;
               count_in    = '0;
               switched_in = 1'b1;
            end
         end else begin
            cand_in  = {1'b0, raw};
            count_in = '0;
         end
      end else begin
         count_in = '0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cur_ff       <= ORIENT_UPRIGHT;
         cand_ff      <= CAND_NONE;
         count_ff     <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_move) begin
            cur_ff   <= cur_in;
            cand_ff  <= cand_in;
            count_ff <= count_in;
         end
      end
      if (in_move) begin
         out_ff.orientation <= cur_in;
         out_ff.switched    <= switched_in;
      end
   end

   // a commit always changes the orientation
   assert property (@(posedge clock) disable iff (reset)
      (in_move && switched_in) |=> (cur_ff != $past(cur_ff)))
      else $error("commit without orientation change");

   // a commit clears the debounce count
   assert property (@(posedge clock) disable iff (reset)
      (in_move && switched_in) |=> (count_ff == '0))
      else $error("count not cleared on commit");

   // the no-candidate code is the only candidate value above the orientations
   assert property (@(posedge clock) disable iff (reset)
      cand_ff[2] |-> (cand_ff == CAND_NONE))
      else $error("bad candidate code");

   // a blocked sample stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_ff)))
      else $error("blocked sample lost");

   // a result is published whenever the state advanced, with the committed orientation
   assert property (@(posedge clock) disable iff (reset)
      in_move |=> out_valid_ff && (out_ff.orientation == cur_ff))
      else $error("result does not match committed orientation");

endmodule

// ===== sim/tilt_orientation_debouncer_tb.sv =====
// ----------------------------------------------------------------------------
// tilt_orientation_debouncer_tb
// Self-checking bench for the tilt orientation debouncer. Accepted samples
// feed a bit-exact orientation tracker that queues the expected results.
// Every returned result is checked field by field against the oldest one.
// Stimulus is a directed opener, then phases of random runs and noise under
// several register settings, with random request gaps and result stall bursts.
// ----------------------------------------------------------------------------
module tilt_orientation_debouncer_tb;
   import tod_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned HoldCycles = 200;
   localparam int          AxisMax    = 32767;

   // tracks committed orientation and queues the results it implies
   class orientation_tracker;
      logic [MagWidth-1:0]   threshold;
      logic [CountWidth-1:0] limit;
      logic [1:0]            committed;
      logic [2:0]            candidate;
      logic [CountWidth-1:0] streak;
      rsp_type               due[$];
      int unsigned           failures;

      function new();
         threshold = THRESHOLD_RESET;
         limit     = LIMIT_RESET;
         committed = ORIENT_UPRIGHT;
         candidate = CAND_NONE;
         streak    = '0;
         failures  = 0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDatWidth-1:0] value);
         case (idx)
            CSR_TILT_THRESHOLD: threshold = value[MagWidth-1:0];
            CSR_DEBOUNCE_LIMIT: limit = value[CountWidth-1:0];
            default: ;
         endcase
      endfunction

      // magnitude with the most negative value pinned to the largest positive
      function int axis_size(logic [AccelWidth-1:0] raw);
         int v;
         v = int'($signed(raw));
         if (v < 0) v = -v;
         return (v > AxisMax) ? AxisMax : v;
      endfunction

      function void note_sample(req_type s);
         int         mx;
         int         my;
         int         thr;
         logic [2:0] raw;
         rsp_type    r;
         mx  = axis_size(s.accel_x);
         my  = axis_size(s.accel_y);
         thr = int'(threshold);
         raw = {1'b0, committed};
         r.switched = 1'b0;
         // classify: y wins only when strictly larger
         if (my > mx) begin
            if (my > thr)
               raw = ($signed(s.accel_y) > 0) ? {1'b0, ORIENT_UPRIGHT} : {1'b0, ORIENT_INVERTED};
         end else if (mx > thr) begin
            raw = ($signed(s.accel_x) > 0) ? {1'b0, ORIENT_RIGHT} : {1'b0, ORIENT_LEFT};
         end
         // debounce toward the candidate
         if (raw != {1'b0, committed}) begin
            if (raw == candidate) begin
               if (streak != COUNT_MAX) streak++;
               if (streak >= limit) begin
                  committed  = raw[1:0];
                  streak     = '0;
                  r.switched = 1'b1;
               end
            end else begin
               candidate = raw;
               streak    = '0;
            end
         end else begin
            streak = '0;
         end
         r.orientation = committed;
         due.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            failures++;
            $error("result with no sample pending: orientation %0d switched %0b",
                   got.orientation, got.switched);
            return;
         end
         want = due.pop_front();
         if (got.orientation !== want.orientation) begin
            failures++;
            $error("orientation mismatch: expected %0d, actual %0d",
                   want.orientation, got.orientation);
         end
         if (got.switched !== want.switched) begin
            failures++;
            $error("switched mismatch: expected %0b, actual %0b", want.switched, got.switched);
         end
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDatWidth-1:0] csr_wdata = '0;

   bit                     idling     = 1'b1;
   bit                     hold_asked = 1'b0;
   int unsigned            cycles     = 0;
   orientation_tracker     tracker;

   tilt_orientation_debouncer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // observe register writes and both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) tracker.note_sample(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
      end
   end

   // result side: random stall bursts, plus one long hold-off when asked
   always begin
      @(posedge clock);
      if (hold_asked) begin
         hold_asked = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HoldCycles) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // offer one sample transaction and wait until it is taken
   task automatic offer(input req_type s);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_xy(input int x, input int y);
      req_type s;
      s.accel_x = x[AccelWidth-1:0];
      s.accel_y = y[AccelWidth-1:0];
      offer(s);
   endtask

   // sample whose dominant axis clears the threshold toward orient
   function automatic req_type aimed_sample(input logic [1:0] orient, input int thr);
      int      peak;
      int      side;
      int      xv;
      int      yv;
      req_type s;
      if (thr >= AxisMax) return req_type'($urandom);
      peak = $urandom_range(AxisMax, thr + 1);
      if (orient == ORIENT_UPRIGHT || orient == ORIENT_INVERTED) begin
         side = $urandom_range(peak - 1, 0);
         xv   = $urandom_range(0, 1) ? -side : side;
         if (orient == ORIENT_UPRIGHT) yv = peak;
         else yv = (peak == AxisMax && $urandom_range(0, 1)) ? -AxisMax - 1 : -peak;
      end else begin
         side = $urandom_range(peak, 0);
         yv   = $urandom_range(0, 1) ? -side : side;
         if (orient == ORIENT_RIGHT) xv = peak;
         else xv = (peak == AxisMax && $urandom_range(0, 1)) ? -AxisMax - 1 : -peak;
      end
      s.accel_x = xv[AccelWidth-1:0];
      s.accel_y = yv[AccelWidth-1:0];
      return s;
   endfunction

   // sample with both axes at or below the threshold
   function automatic req_type quiet_sample(input int thr);
      int      xv;
      int      yv;
      req_type s;
      xv = $urandom_range(thr, 0);
      yv = $urandom_range(thr, 0);
      if ($urandom_range(0, 1)) xv = -xv;
      if ($urandom_range(0, 1)) yv = -yv;
      s.accel_x = xv[AccelWidth-1:0];
      s.accel_y = yv[AccelWidth-1:0];
      return s;
   endfunction

   // mostly runs of one orientation, with noise and quiet samples between
   task automatic run_mixed(input int unsigned count, input int thr,
                            input int unsigned run_lo, input int unsigned run_hi);
      int unsigned sent;
      int unsigned run;
      logic [1:0]  orient;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               offer(req_type'($urandom));
               sent++;
            end
            2: begin
               offer(quiet_sample(thr));
               sent++;
            end
            default: begin
               orient = 2'($urandom_range(0, 3));
               run    = $urandom_range(run_hi, run_lo);
               repeat (run) begin
                  offer(aimed_sample(orient, thr));
                  sent++;
               end
            end
         endcase
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due.size() != 0) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic retune(input logic [CsrDatWidth-1:0] thr, input logic [CsrDatWidth-1:0] lim);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TILT_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int thr;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opener at reset settings
      send_xy(0, 0);
      send_xy(2500, 0);
      send_xy(2501, 0);
      repeat (3) send_xy(32767, 100);
      send_xy(-32768, 0);
      // ties go to x
      send_xy(-32768, -32768);
      send_xy(-3000, 3000);
      send_xy(-2600, -2599);
      send_xy(0, 32767);
      // quiet sample clears the count
      send_xy(0, 0);
      repeat (4) send_xy(100, 32767);
      send_xy(0, -32768);
      send_xy(32767, -32768);
      repeat (3) send_xy(5, -32768);
      send_xy(-1, -2501);
      // candidate kept after commit
      send_xy(3000, 0);
      send_xy(1, 0);

      // lowest threshold, shortest debounce
      retune(15'd0, 15'd1);
      run_mixed(200, 0, 1, 4);

      // highest threshold: orientation never moves
      retune(15'd32767, 15'd255);
      run_mixed(80, AxisMax, 1, 4);

      // zero debounce limit behaves as one
      thr = $urandom_range(30000, 1);
      retune(15'(thr), 15'd0);
      run_mixed(200, thr, 1, 4);

      // longest debounce, upper data bits set on the limit write
      thr = $urandom_range(30000, 1);
      retune(15'(thr), {7'h5A, 8'd255});
      run_mixed(480, thr, 250, 262);

      // long result hold-off while samples keep coming
      thr = $urandom_range(30000, 1);
      retune(15'(thr), 15'($urandom_range(8, 1)));
      hold_asked = 1'b1;
      run_mixed(300, thr, 1, 12);

      // back to reset values, full rate
      idling = 1'b0;
      retune(THRESHOLD_RESET, 15'(LIMIT_RESET));
      run_mixed(250, 2500, 1, 6);

      settle();
      repeat (6) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
